@@ design/dtfs_pkg.sv @@
// shared types, constants and register codes of the delimited text field splitter
`timescale 1ns / 1ps

package dtfs_pkg;

	// default largest delimiter the window can hold
	localparam int MAX_DELIM_BYTES_DEF = 8;

	// line terminator
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

	// register file index width and register codes
	localparam int CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_LINES       = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER_BYTES  = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER_LENGTH = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT     = 8'd3;

	// register reset values
	localparam logic [15:0] SKIP_LINES_RST       = 16'd0;
	localparam logic [63:0] DELIMITER_BYTES_RST  = 64'd9;
	localparam logic [3:0]  DELIMITER_LENGTH_RST = 4'd1;
	localparam logic [7:0]  COLUMN_COUNT_RST     = 8'd255;

	// result kinds
	typedef enum logic [1:0] {
		KIND_DATA           = 2'd0,
		KIND_FIELD_END      = 2'd1,
		KIND_FIELD_LINE_END = 2'd2,
		KIND_LINE_END       = 2'd3
	} kind_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic step;
		logic flush_byte;
		logic flush_end;
		logic finish;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic skipping;
		logic newline;
		logic loop_go;
		logic fill_zero;
		logic out_free;
		logic hold_valid;
	} status_t;

endpackage

@@ design/dtfs_ifs.sv @@
// channel interfaces: text input, result output and register writes
`timescale 1ns / 1ps

interface dtfs_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface dtfs_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic [7:0] column;
	logic       last;

	modport source (output valid, output kind, output out_byte, output column, output last,
		input ready);
	modport sink (input valid, input kind, input out_byte, input column, input last,
		output ready);
endinterface

interface dtfs_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [dtfs_pkg::CFG_INDEX_W-1:0] index;
	logic [63:0]                     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/dtfs_controller.sv @@
// sequencing state machine of the field splitter
`timescale 1ns / 1ps

module dtfs_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dtfs_pkg::status_t status,
	output dtfs_pkg::cmd_t    cmd
);

	dtfs_pkg::state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			dtfs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.skipping) begin
						state_nxt = dtfs_pkg::ST_IDLE;
					end else if (status.newline) begin
						state_nxt = dtfs_pkg::ST_FLUSH;
					end else begin
						state_nxt = dtfs_pkg::ST_SPLIT;
					end
				end
			end
			// one match decision per cycle while the output is free, until the window is short
			dtfs_pkg::ST_SPLIT: begin
				if (!status.loop_go) begin
					state_nxt = dtfs_pkg::ST_FINISH;
				end else if (status.out_free) begin
					cmd.step = 1'b1;
				end
			end
			// held bytes out as data, then the line marker
			dtfs_pkg::ST_FLUSH: begin
				if (status.out_free) begin
					if (!status.fill_zero) begin
						cmd.flush_byte = 1'b1;
					end else begin
						cmd.flush_end = 1'b1;
						state_nxt     = dtfs_pkg::ST_FINISH;
					end
				end
			end
			// release the held result tagged as last
			dtfs_pkg::ST_FINISH: begin
				if (!status.hold_valid) begin
					state_nxt = dtfs_pkg::ST_IDLE;
				end else if (status.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = dtfs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = dtfs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/dtfs_datapath.sv @@
// registers, match window, compare and result staging of the field splitter
`timescale 1ns / 1ps

module dtfs_datapath #(
	parameter int MAX_DELIM_BYTES = dtfs_pkg::MAX_DELIM_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [dtfs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]                      cfg_data,
	input  logic [7:0]                       in_byte,
	input  dtfs_pkg::cmd_t                   cmd,
	output dtfs_pkg::status_t                status,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       out_kind,
	output logic [7:0]                       out_byte,
	output logic [7:0]                       out_column,
	output logic                             out_last
);

	localparam int FILL_W = $clog2(MAX_DELIM_BYTES + 1);
	localparam int IDX_W  = (MAX_DELIM_BYTES > 1) ? $clog2(MAX_DELIM_BYTES) : 1;
	localparam int SUM_W  = FILL_W + 1;

	// configuration registers
	logic [15:0] skip_q;
	logic [63:0] delim_q;
	logic [3:0]  dlen_q;
	logic [7:0]  cols_q;

	// line state
	logic [7:0]        win_q [MAX_DELIM_BYTES];
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        col_q;
	logic [15:0]       lines_q;

	// held result and output register
	logic                hold_valid_q;
	dtfs_pkg::kind_t     hold_kind_q;
	logic [7:0]          hold_byte_q;
	logic [7:0]          hold_col_q;
	logic                out_valid_q;
	dtfs_pkg::kind_t     out_kind_q;
	logic [7:0]          out_byte_q;
	logic [7:0]          out_col_q;
	logic                out_last_q;

	logic [FILL_W-1:0] len;
	logic              kept;
	logic              hit;
	logic              out_free;
	logic              out_load;
	logic [7:0]        col_inc;
	logic [15:0]       lines_inc;
	logic [7:0]        win_drop1 [MAX_DELIM_BYTES];
	logic [7:0]        win_dropn [MAX_DELIM_BYTES];
	logic              cand_emit;
	dtfs_pkg::kind_t   cand_kind;
	logic [7:0]        cand_byte;

	// register writes, ready is always high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q  <= dtfs_pkg::SKIP_LINES_RST;
			delim_q <= dtfs_pkg::DELIMITER_BYTES_RST;
			dlen_q  <= dtfs_pkg::DELIMITER_LENGTH_RST;
			cols_q  <= dtfs_pkg::COLUMN_COUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				dtfs_pkg::CFG_SKIP_LINES:       skip_q  <= cfg_data[15:0];
				dtfs_pkg::CFG_DELIMITER_BYTES:  delim_q <= cfg_data;
				dtfs_pkg::CFG_DELIMITER_LENGTH: dlen_q  <= cfg_data[3:0];
				dtfs_pkg::CFG_COLUMN_COUNT:     cols_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// effective delimiter length, clamped to one..max
	always_comb begin
		if (dlen_q == 4'd0) begin
			len = FILL_W'(1);
		end else if (32'(dlen_q) > MAX_DELIM_BYTES) begin
			len = FILL_W'(MAX_DELIM_BYTES);
		end else begin
			len = FILL_W'(dlen_q);
		end
	end

	assign kept      = col_q < cols_q;
	assign col_inc   = (col_q != 8'hFF) ? col_q + 8'd1 : col_q;
	assign lines_inc = (lines_q != 16'hFFFF) ? lines_q + 16'd1 : lines_q;
	assign out_free  = !out_valid_q || out_ready;

	// delimiter compare over the front of the window
	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
			if ((SUM_W'(i) < {1'b0, len}) && (win_q[i] != delim_q[8*i +: 8])) begin
				hit = 1'b0;
			end
		end
	end

	// window shifted by one byte and by the delimiter length
	always_comb begin
		logic [SUM_W-1:0] src;
		src = '0;
		for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
			if (i + 1 < MAX_DELIM_BYTES) begin
				win_drop1[i] = win_q[i+1];
			end else begin
				win_drop1[i] = 8'h00;
			end
			src = SUM_W'(i) + {1'b0, len};
			if (src < SUM_W'(MAX_DELIM_BYTES)) begin
				win_dropn[i] = win_q[src[IDX_W-1:0]];
			end else begin
				win_dropn[i] = 8'h00;
			end
		end
	end

	// result candidate of this cycle
	always_comb begin
		cand_emit = 1'b0;
		cand_kind = dtfs_pkg::KIND_DATA;
		cand_byte = 8'h00;
		if (cmd.step) begin
			cand_emit = kept;
			if (hit) begin
				cand_kind = dtfs_pkg::KIND_FIELD_END;
			end else begin
				cand_byte = win_q[0];
			end
		end else if (cmd.flush_byte) begin
			cand_emit = kept;
			cand_byte = win_q[0];
		end else if (cmd.flush_end) begin
			cand_emit = 1'b1;
			cand_kind = kept ? dtfs_pkg::KIND_FIELD_LINE_END : dtfs_pkg::KIND_LINE_END;
		end
	end

	assign out_load = hold_valid_q && (cand_emit || cmd.finish);

	// window, column and line counter updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
				win_q[i] <= 8'h00;
			end
			fill_q  <= '0;
			col_q   <= '0;
			lines_q <= '0;
		end else if (cmd.accept) begin
			if (status.skipping) begin
				for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
					win_q[i] <= 8'h00;
				end
				fill_q <= '0;
				col_q  <= '0;
				if (status.newline) begin
					lines_q <= lines_inc;
				end
			end else if (!status.newline && (32'(fill_q) < MAX_DELIM_BYTES)) begin
				win_q[fill_q[IDX_W-1:0]] <= in_byte;
				fill_q <= fill_q + FILL_W'(1);
			end
		end else if (cmd.step) begin
			if (hit) begin
				win_q  <= win_dropn;
				fill_q <= fill_q - len;
				col_q  <= col_inc;
			end else begin
				win_q  <= win_drop1;
				fill_q <= fill_q - FILL_W'(1);
			end
		end else if (cmd.flush_byte) begin
			win_q  <= win_drop1;
			fill_q <= fill_q - FILL_W'(1);
		end else if (cmd.flush_end) begin
			for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
				win_q[i] <= 8'h00;
			end
			fill_q  <= '0;
			col_q   <= '0;
			lines_q <= lines_inc;
		end
	end

	// hold stage: a result waits until the next one shows whether it is last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (cand_emit) begin
			hold_valid_q <= 1'b1;
		end else if (cmd.finish) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cand_emit) begin
			hold_kind_q <= cand_kind;
			hold_byte_q <= cand_byte;
			hold_col_q  <= col_q;
		end
	end

	// output register and its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= hold_kind_q;
			out_byte_q <= hold_byte_q;
			out_col_q  <= hold_col_q;
			out_last_q <= cmd.finish;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_byte   = out_byte_q;
	assign out_column = out_col_q;
	assign out_last   = out_last_q;

	// status to the controller
	assign status.skipping   = lines_q < skip_q;
	assign status.newline    = in_byte == dtfs_pkg::NEWLINE_BYTE;
	assign status.loop_go    = fill_q >= len;
	assign status.fill_zero  = fill_q == '0;
	assign status.out_free   = out_free;
	assign status.hold_valid = hold_valid_q;

endmodule

@@ design/delimited_text_field_splitter.sv @@
// Delimited text field splitter: splits a byte stream into lines and fields.
//
// Channels: text takes one raw byte per transfer; result gives one item per
// transfer (kind, out_byte, column, last); cfg writes one register per
// transfer (index 0 skip_lines, 1 delimiter_bytes, 2 delimiter_length,
// 3 column_count) and is always ready. Write cfg only while the block idles.
// Sequence: a byte of a skipped line is only accepted. Any other non-newline
// byte is accepted, then gets one match decision of the window per step
// (a hit, a data byte or a suppressed byte alike), then a check that the window
// is short and a finish step. A newline is accepted, then each held byte goes
// out as data, then the marker, then the finish step.
// Staging: a result waits in a hold stage and reaches the output register at
// the edge where the next result of the same byte is found; the last one
// gets there with the finish step, after the window check or the line marker.
// A stalled receiver holds the output register and freezes the sequencer;
// the next byte is still accepted once the previous one has finished.
// Reset clears registers to defaults, the window, column and line count.

`timescale 1ns / 1ps

module delimited_text_field_splitter #(
	parameter int MAX_DELIM_BYTES = dtfs_pkg::MAX_DELIM_BYTES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	dtfs_text_if.sink    text,
	dtfs_result_if.source result,
	dtfs_cfg_if.sink     cfg
);

	dtfs_pkg::cmd_t    cmd;
	dtfs_pkg::status_t status;

	assign cfg.ready = 1'b1;

	// sequencer
	dtfs_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text.valid),
		.in_ready (text.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// window, counters and output staging
	dtfs_datapath #(
		.MAX_DELIM_BYTES (MAX_DELIM_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.in_byte    (text.in_byte),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_kind   (result.kind),
		.out_byte   (result.out_byte),
		.out_column (result.column),
		.out_last   (result.last)
	);

endmodule

@@ dv/testbench.sv @@
// self-checking testbench of the delimited text field splitter
`timescale 1ns / 1ps

module testbench;

	localparam logic [dtfs_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 8'd7;
	localparam logic [7:0] TAB_BYTE = 8'h09;
	localparam logic [31:0] DELIM_ALPHABET = {",", ";", "a", "b"};
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int RUN_LIMIT_NS = 8_000_000;
	localparam int PHASE_LENS [8] = '{1, 0, 8, 3, 5, 2, 1, 15};
	localparam int PHASE_COLS [8] = '{255, 0, 2, 1, 255, 3, 255, 7};

	typedef struct packed {
		dtfs_pkg::kind_t kind;
		logic [7:0]      data;
		logic [7:0]      col;
		logic            last;
	} split_result_t;

	logic clk = 1'b0;
	logic arst_n;

	dtfs_text_if   text_ch ();
	dtfs_result_if result_ch ();
	dtfs_cfg_if    cfg_ch ();

	delimited_text_field_splitter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// predicted register copies and splitter state
	logic [15:0] skip_reg;
	logic [63:0] delim_reg;
	logic [3:0]  dlen_reg;
	logic [7:0]  cols_reg;
	logic [7:0]  win [8];
	logic [3:0]  win_fill;
	logic [7:0]  col_idx;
	logic [15:0] lines_cnt;

	split_result_t field_q [$];
	logic [7:0]    text_q [$];

	int errors = 0;
	int bytes_in = 0;
	int results_out = 0;
	int reg_writes = 0;
	int queued_total = 0;
	int idle_pct = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit hold_go = 1'b0;
	logic long_hold;

	always #4 clk = ~clk;

	function automatic int delim_span();
		if (dlen_reg == 4'd0) return 1;
		if (dlen_reg > 4'd8) return 8;
		return int'(dlen_reg);
	endfunction

	function automatic bit column_kept();
		return col_idx < cols_reg;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(99) < 88) return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	task automatic shift_window(input int n);
		for (int i = 0; i < 8; i++)
			win[i] = (i + n < 8) ? win[i + n] : 8'h00;
		win_fill = (win_fill >= n) ? 4'(int'(win_fill) - n) : 4'd0;
	endtask

	task automatic add_result(input dtfs_pkg::kind_t k, input logic [7:0] d);
		split_result_t r;
		r.kind = k;
		r.data = d;
		r.col = col_idx;
		r.last = 1'b0;
		field_q.push_back(r);
	endtask

	// expected results of one accepted text byte
	task automatic split_byte(input logic [7:0] b);
		int dl;
		int start_n;
		bit hit;
		split_result_t r;
		dl = delim_span();
		start_n = field_q.size();
		if (lines_cnt < skip_reg) begin
			shift_window(8);
			col_idx = 8'd0;
			if (b == dtfs_pkg::NEWLINE_BYTE && lines_cnt != 16'hFFFF) lines_cnt++;
		end else if (b == dtfs_pkg::NEWLINE_BYTE) begin
			// flush held bytes, then close the line
			for (int i = 0; i < win_fill; i++)
				if (column_kept()) add_result(dtfs_pkg::KIND_DATA, win[i]);
			add_result(column_kept() ? dtfs_pkg::KIND_FIELD_LINE_END : dtfs_pkg::KIND_LINE_END,
				8'h00);
			shift_window(8);
			col_idx = 8'd0;
			if (lines_cnt != 16'hFFFF) lines_cnt++;
		end else begin
			if (win_fill < 4'd8) begin
				win[win_fill] = b;
				win_fill++;
			end
			// leftmost match decisions while the window is long enough
			while (win_fill >= dl) begin
				hit = 1'b1;
				for (int i = 0; i < dl; i++)
					if (win[i] != delim_reg[8*i +: 8]) hit = 1'b0;
				if (hit) begin
					if (column_kept()) add_result(dtfs_pkg::KIND_FIELD_END, 8'h00);
					if (col_idx != 8'hFF) col_idx++;
					shift_window(dl);
				end else begin
					if (column_kept()) add_result(dtfs_pkg::KIND_DATA, win[0]);
					shift_window(1);
				end
			end
		end
		if (field_q.size() > start_n) begin
			r = field_q.pop_back();
			r.last = 1'b1;
			field_q.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string msg);
		errors++;
		$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	// register write over the cfg channel, mirrored into the predictor
	task automatic write_reg(input logic [dtfs_pkg::CFG_INDEX_W-1:0] idx,
		input logic [63:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			dtfs_pkg::CFG_SKIP_LINES:       skip_reg = val[15:0];
			dtfs_pkg::CFG_DELIMITER_BYTES:  delim_reg = val;
			dtfs_pkg::CFG_DELIMITER_LENGTH: dlen_reg = val[3:0];
			dtfs_pkg::CFG_COLUMN_COUNT:     cols_reg = val[7:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic apply_config(input logic [15:0] sk, input logic [63:0] dv, input int dl,
		input int cols);
		write_reg(dtfs_pkg::CFG_SKIP_LINES, {48'h0, sk});
		write_reg(dtfs_pkg::CFG_DELIMITER_BYTES, dv);
		write_reg(dtfs_pkg::CFG_DELIMITER_LENGTH, 64'(dl));
		write_reg(dtfs_pkg::CFG_COLUMN_COUNT, 64'(cols));
	endtask

	task automatic push_text(input logic [7:0] b);
		text_q.push_back(b);
		queued_total++;
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++) push_text(s[i]);
	endtask

	// content byte, biased toward delimiter bytes to provoke partial matches
	function automatic logic [7:0] pick_char();
		int r;
		int k;
		r = $urandom_range(99);
		k = $urandom_range(delim_span() - 1);
		if (r < 45) return delim_reg[8*k +: 8];
		if (r < 55) return 8'h00;
		if (r < 62) return 8'hFF;
		if (r < 64) return dtfs_pkg::NEWLINE_BYTE;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [63:0] random_delim();
		logic [63:0] d;
		for (int i = 0; i < 8; i++)
			d[8*i +: 8] = DELIM_ALPHABET[8*$urandom_range(3) +: 8];
		return d;
	endfunction

	// one line of fields with random content, sometimes broken
	task automatic queue_line();
		int nf;
		int span;
		int cut;
		nf = $urandom_range(1, 5);
		span = delim_span();
		for (int f = 0; f < nf; f++) begin
			if (f > 0) begin
				cut = ($urandom_range(9) == 0) ? $urandom_range(span - 1) : span;
				for (int i = 0; i < cut; i++) push_text(delim_reg[8*i +: 8]);
			end
			repeat ($urandom_range(0, 4)) push_text(pick_char());
		end
		if ($urandom_range(19) != 0) push_text(dtfs_pkg::NEWLINE_BYTE);
	endtask

	task automatic queue_lines(input int n);
		int target;
		target = queued_total + n;
		while (queued_total < target) queue_line();
	endtask

	// wait until all bytes are sent and all results have come, then settle
	task automatic drain();
		while (text_q.size() != 0 || field_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// text driver: offers queued bytes, predicts on each transfer
	always @(posedge clk) begin : text_driver
		logic       nv;
		logic [7:0] nb;
		logic [7:0] sent;
		nv = 1'b0;
		nb = arst_n ? text_ch.in_byte : 8'h00;
		if (text_ch.valid && text_ch.ready) begin
			sent = text_q.pop_front();
			split_byte(sent);
			bytes_in++;
		end
		if (text_ch.valid && !text_ch.ready) begin
			nv = 1'b1;
		end else if (send_gap > 0) begin
			send_gap--;
		end else if (text_q.size() != 0) begin
			if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
				send_gap = gap_len() - 1;
			end else begin
				nv = 1'b1;
				nb = text_q[0];
			end
		end
		text_ch.valid <= nv;
		text_ch.in_byte <= nb;
	end

	// result monitor: checks each transfer against the oldest expectation
	always @(posedge clk) begin : result_monitor
		split_result_t want;
		logic          nr;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_out++;
			if (field_q.size() == 0) begin
				report_mismatch($sformatf("result kind %0d col %0d with nothing expected",
					result_ch.kind, result_ch.column));
			end else begin
				want = field_q.pop_front();
				if (result_ch.kind !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d",
						result_ch.kind, want.kind));
				if (result_ch.out_byte !== want.data)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						result_ch.out_byte, want.data));
				if (result_ch.column !== want.col)
					report_mismatch($sformatf("column %0d, expected %0d",
						result_ch.column, want.col));
				if (result_ch.last !== want.last)
					report_mismatch($sformatf("last %0b, expected %0b",
						result_ch.last, want.last));
			end
		end
		if (long_hold) begin
			nr = 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			nr = 1'b0;
		end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			recv_gap = gap_len() - 1;
			nr = 1'b0;
		end else begin
			nr = 1'b1;
		end
		result_ch.ready <= nr;
	end

	// long receiver hold-off so the block backs up onto its input
	initial begin
		long_hold <= 1'b0;
		wait (hold_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("delimited_text_field_splitter verification failed");
		$finish;
	end

	// stimulus sequence
	initial begin
		skip_reg = dtfs_pkg::SKIP_LINES_RST;
		delim_reg = dtfs_pkg::DELIMITER_BYTES_RST;
		dlen_reg = dtfs_pkg::DELIMITER_LENGTH_RST;
		cols_reg = dtfs_pkg::COLUMN_COUNT_RST;
		for (int i = 0; i < 8; i++) win[i] = 8'h00;
		win_fill = 4'd0;
		col_idx = 8'd0;
		lines_cnt = 16'd0;
		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: byte extremes, adjacent tabs, empty line
		push_text("a");
		push_text(8'h00);
		push_text(8'hFF);
		push_text(TAB_BYTE);
		push_text(TAB_BYTE);
		push_text("b");
		push_text(dtfs_pkg::NEWLINE_BYTE);
		push_text(dtfs_pkg::NEWLINE_BYTE);
		drain();

		// every column suppressed: line end only
		write_reg(dtfs_pkg::CFG_COLUMN_COUNT, 64'd0);
		queue_text("q\tr\n");
		drain();

		// self-overlapping delimiter, then length shrunk mid-line
		write_reg(dtfs_pkg::CFG_COLUMN_COUNT, 64'd255);
		write_reg(dtfs_pkg::CFG_DELIMITER_BYTES, 64'h6261_6261);
		write_reg(dtfs_pkg::CFG_DELIMITER_LENGTH, 64'd4);
		queue_text("xaba");
		drain();
		write_reg(dtfs_pkg::CFG_DELIMITER_LENGTH, 64'd2);
		queue_text("c\n");
		drain();

		// skipped line, then a kept one
		write_reg(dtfs_pkg::CFG_SKIP_LINES, {48'h0, lines_cnt + 16'd1});
		queue_text("s\t\nk\n");
		drain();
		write_reg(CFG_UNUSED_INDEX, '1);

		// random phases over a spread of settings
		for (int p = 0; p < 8; p++) begin
			logic [63:0] dv;
			logic [15:0] sk;
			int          nbytes;
			case (p)
				1: dv = 64'h0;
				4: dv = '1;
				5: dv = {48'h0, dtfs_pkg::NEWLINE_BYTE, 8'h2C};
				default: dv = random_delim();
			endcase
			sk = (p == 3) ? lines_cnt + 16'd2 : ((p == 6) ? 16'hFFFF : 16'd0);
			nbytes = (p == 6) ? 12 : 30;
			idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 25 : 50);
			apply_config(sk, dv, PHASE_LENS[p], PHASE_COLS[p]);
			if (p == 2) hold_go = 1'b1;
			queue_lines(nbytes);
			drain();
		end

		// column index runs past 255 and saturates
		idle_pct = 25;
		apply_config(16'd0, 64'(TAB_BYTE), 1, 255);
		repeat (258) push_text(TAB_BYTE);
		queue_text("x\n");
		drain();

		// unterminated final line
		queue_text("end");
		drain();

		$display("run covered %0d text bytes, %0d results checked, %0d register writes",
			bytes_in, results_out, reg_writes);
		$display("settings spanned delimiter lengths 0 to 15, column counts 0 to 255, %s",
			"skipped lines and a long receiver hold");
		if (errors == 0) begin
			$display("delimited_text_field_splitter verification clean");
		end else begin
			$display("delimited_text_field_splitter verification failed");
		end
		$finish;
	end

endmodule
